### sv/iate_pkg.sv
package iate_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int POS_W = 7;
  localparam int VAL_W = 32;

  // opcodes
  localparam logic [2:0] OP_LIST   = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_SEARCH = 3'd4;

  // result status
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    C_HOLD,
    C_INS,
    C_DEL,
    C_UPD,
    C_ROT
  } cell_op_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e          op;
    logic [POS_W-1:0]  pidx;   // zero-based target position
    logic [POS_W-1:0]  tail;   // index of the last element in use
    logic [VAL_W-1:0]  wdata;
  } cell_cmd_t;

endpackage

### sv/iate_cell.sv
module iate_cell
  import iate_pkg::*;
(
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_cmd_t        cmd_i,
  input  logic [VAL_W-1:0] left_i,
  input  logic [VAL_W-1:0] right_i,
  input  logic [VAL_W-1:0] head_i,
  output logic [VAL_W-1:0] value_o,
  output logic [VAL_W-1:0] sel_value_o
);

  logic [VAL_W-1:0] value_q, value_d;
  logic [POS_W-1:0] idx;

  assign idx = POS_W'(idx_i);

  always_comb begin
    value_d = value_q;
    unique case (cmd_i.op)
      C_INS: begin
        if (idx == cmd_i.pidx) begin
          value_d = cmd_i.wdata;
        end else if (idx > cmd_i.pidx) begin
          value_d = left_i;
        end
      end
      C_DEL: begin
        if (idx >= cmd_i.pidx && idx < cmd_i.tail) begin
          value_d = right_i;
        end
      end
      C_UPD: begin
        if (idx == cmd_i.pidx) begin
          value_d = cmd_i.wdata;
        end
      end
      C_ROT: begin
        // head wraps around to the tail of the used part
        if (idx == cmd_i.tail) begin
          value_d = head_i;
        end else if (idx < cmd_i.tail) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o     = value_q;
  assign sel_value_o = (idx == cmd_i.pidx) ? value_q : '0;

endmodule

### sv/indexed_array_table_engine_unit.sv
// Single-result operations (insert, delete, update, list or search of an empty table)
// shift or write the whole cell chain at once, result registered next edge.
// A listing emits one item per cycle while the output is not stalled; both it and a
// search rotate the cell chain one position per step past the head cell.
// Reset clears the state, element count and output valid; element cells are not reset.
module indexed_array_table_engine_unit
  import iate_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              opcode_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic signed [VAL_W-1:0] element_value_o,
  output logic [POS_W-1:0]        element_position_o,
  output logic                    last_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LIST = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [POS_W-1:0] count_q, count_d;
  logic [POS_W-1:0] k_q, k_d;
  logic [VAL_W-1:0] key_q, key_d;
  logic             found_q, found_d;
  logic [POS_W-1:0] fpos_q, fpos_d;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [VAL_W-1:0] oval_q, oval_d;
  logic [POS_W-1:0] opos_q, opos_d;
  logic             last_q, last_d;

  logic             out_free, accept, at_tail, hit;
  logic [POS_W:0]   pos_ext, cnt_ext;
  logic             del_range_bad, ins_range_bad, full;
  cell_cmd_t        cmd;

  logic [VAL_W-1:0] cell_val [DEPTH];
  logic [VAL_W-1:0] cell_sel [DEPTH];
  logic [VAL_W-1:0] removed;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [VAL_W-1:0] left, right;
      if (g == 0) begin : g_first
        assign left = '0;
      end else begin : g_mid_l
        assign left = cell_val[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid_r
        assign right = cell_val[g+1];
      end
      iate_cell u_cell (
        .clk_i       (clk_i),
        .idx_i       (IDX_W'(g)),
        .cmd_i       (cmd),
        .left_i      (left),
        .right_i     (right),
        .head_i      (cell_val[0]),
        .value_o     (cell_val[g]),
        .sel_value_o (cell_sel[g])
      );
    end
  endgenerate

  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | cell_sel[i];
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_ext       = {1'b0, position_i};
  assign cnt_ext       = {1'b0, count_q};
  assign full          = (cnt_ext >= (POS_W+1)'(DEPTH));
  assign ins_range_bad = (position_i == '0) || (pos_ext > cnt_ext + (POS_W+1)'(1));
  assign del_range_bad = (position_i == '0) || (pos_ext > cnt_ext);
  assign at_tail       = (k_q == count_q - POS_W'(1));
  assign hit           = (cell_val[0] == key_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    key_d       = key_q;
    found_d     = found_q;
    fpos_d      = fpos_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    oval_d      = oval_q;
    opos_d      = opos_q;
    last_d      = last_q;

    cmd.op    = C_HOLD;
    cmd.pidx  = position_i - POS_W'(1);
    cmd.tail  = count_q - POS_W'(1);
    cmd.wdata = value_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          status_d = STAT_OK;
          oval_d   = value_i;
          opos_d   = position_i;
          last_d   = 1'b1;
          unique case (opcode_i)
            OP_LIST: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                oval_d      = '0;
                opos_d      = '0;
              end else begin
                state_d = ST_LIST;
                k_d     = '0;
              end
            end
            OP_INSERT: begin
              out_valid_d = 1'b1;
              if (full) begin
                status_d = STAT_FULL;
                opos_d   = '0;
              end else if (ins_range_bad) begin
                status_d = STAT_RANGE;
                opos_d   = '0;
              end else begin
                cmd.op  = C_INS;
                count_d = count_q + POS_W'(1);
              end
            end
            OP_DELETE: begin
              out_valid_d = 1'b1;
              if (del_range_bad) begin
                status_d = STAT_RANGE;
                opos_d   = '0;
              end else begin
                cmd.op  = C_DEL;
                count_d = count_q - POS_W'(1);
                oval_d  = removed;
              end
            end
            OP_UPDATE: begin
              out_valid_d = 1'b1;
              if (del_range_bad) begin
                status_d = STAT_RANGE;
                opos_d   = '0;
              end else begin
                cmd.op = C_UPD;
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                status_d    = STAT_NOTFOUND;
                opos_d      = '0;
              end else begin
                state_d = ST_SRCH;
                k_d     = '0;
                key_d   = value_i;
                found_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LIST: begin
        if (out_free) begin
          cmd.op      = C_ROT;
          out_valid_d = 1'b1;
          status_d    = STAT_OK;
          oval_d      = cell_val[0];
          opos_d      = k_q + POS_W'(1);
          last_d      = at_tail;
          k_d         = k_q + POS_W'(1);
          if (at_tail) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SRCH: begin
        if (!at_tail) begin
          cmd.op = C_ROT;
          k_d    = k_q + POS_W'(1);
          if (!found_q && hit) begin
            found_d = 1'b1;
            fpos_d  = k_q + POS_W'(1);
          end
        end else if (out_free) begin
          // final rotation brings the chain back to its original order
          cmd.op      = C_ROT;
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          oval_d      = key_q;
          last_d      = 1'b1;
          if (found_q) begin
            status_d = STAT_OK;
            opos_d   = fpos_q;
          end else if (hit) begin
            status_d = STAT_OK;
            opos_d   = k_q + POS_W'(1);
          end else begin
            status_d = STAT_NOTFOUND;
            opos_d   = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    key_q    <= key_d;
    found_q  <= found_d;
    fpos_q   <= fpos_d;
    status_q <= status_d;
    oval_q   <= oval_d;
    opos_q   <= opos_d;
    last_q   <= last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign element_value_o    = oval_q;
  assign element_position_o = opos_q;
  assign last_o             = last_q;

endmodule

### test/tb_indexed_array_table_engine_unit.sv
module tb_indexed_array_table_engine_unit
  import iate_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int SCRIPT_LEN = 26;

  // opcodes the block ignores
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    logic             last;
  } table_reply_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    logic             typed;
    logic [1:0]       st;
    logic [VAL_W-1:0] eval;
    logic [POS_W-1:0] epos;
  } script_row_t;

  // typed rows hold a single known reply; the rest go through the shadow table
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_LIST,        7'd0,   32'h0000_0000, 1'b1, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_SEARCH,      7'd0,   32'h0000_0005, 1'b1, STAT_NOTFOUND, 32'h0000_0005, 7'd0},
    '{OP_DELETE,      7'd1,   32'h0000_0007, 1'b1, STAT_RANGE,    32'h0000_0007, 7'd0},
    '{OP_UPDATE,      7'd1,   32'h0000_0009, 1'b1, STAT_RANGE,    32'h0000_0009, 7'd0},
    '{OP_INSERT,      7'd0,   32'h0000_0001, 1'b1, STAT_RANGE,    32'h0000_0001, 7'd0},
    '{OP_INSERT,      7'd2,   32'h0000_0003, 1'b1, STAT_RANGE,    32'h0000_0003, 7'd0},
    '{OP_INSERT,      7'd127, 32'hFFFF_FFFF, 1'b1, STAT_RANGE,    32'hFFFF_FFFF, 7'd0},
    '{OP_INSERT,      7'd1,   32'h8000_0000, 1'b1, STAT_OK,       32'h8000_0000, 7'd1},
    '{OP_INSERT,      7'd2,   32'h7FFF_FFFF, 1'b1, STAT_OK,       32'h7FFF_FFFF, 7'd2},
    '{OP_INSERT,      7'd1,   32'h0000_0000, 1'b1, STAT_OK,       32'h0000_0000, 7'd1},
    '{OP_INSERT,      7'd2,   32'hFFFF_FFFF, 1'b1, STAT_OK,       32'hFFFF_FFFF, 7'd2},
    '{OP_LIST,        7'd0,   32'h0000_0000, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_SEARCH,      7'd0,   32'h7FFF_FFFF, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_SEARCH,      7'd0,   32'h0000_0000, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_UPDATE,      7'd3,   32'h1234_5678, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_UPDATE,      7'd5,   32'h0000_0000, 1'b1, STAT_RANGE,    32'h0000_0000, 7'd0},
    '{OP_DELETE,      7'd5,   32'hAAAA_5555, 1'b1, STAT_RANGE,    32'hAAAA_5555, 7'd0},
    '{OP_DELETE,      7'd2,   32'h0000_0000, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_SPARE_FIRST, 7'd1,   32'h0000_0011, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_SPARE_LAST,  7'd127, 32'hFFFF_FFFF, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_DELETE,      7'd127, 32'h55AA_55AA, 1'b1, STAT_RANGE,    32'h55AA_55AA, 7'd0},
    '{OP_INSERT,      7'd4,   32'h1234_5678, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_SEARCH,      7'd0,   32'h1234_5678, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_DELETE,      7'd4,   32'h0000_0000, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_UPDATE,      7'd1,   32'hFFFF_FFFF, 1'b0, STAT_OK,       32'h0000_0000, 7'd0},
    '{OP_LIST,        7'd0,   32'h0000_0000, 1'b0, STAT_OK,       32'h0000_0000, 7'd0}
  };

  logic             clk_i = 1'b0;
  logic             rst_n = 1'b0;
  logic             item_valid = 1'b0;
  logic [2:0]       item_opcode = OP_LIST;
  logic [POS_W-1:0] item_position = '0;
  logic [VAL_W-1:0] item_value = '0;
  logic             item_typed = 1'b0;
  table_reply_t     item_reply = '0;
  logic             reply_stall = 1'b0;

  wire              item_stall;
  wire              reply_valid;
  wire [1:0]        reply_status;
  wire [VAL_W-1:0]  reply_value;
  wire [POS_W-1:0]  reply_position;
  wire              reply_last;

  logic [VAL_W-1:0] shadow_elems [DEPTH];
  int               shadow_count = 0;
  table_reply_t     replies_due [$];
  int               mismatch_count = 0;

  bit tx_gaps_on = 1'b0;
  bit rx_gaps_on = 1'b0;
  bit hold_request = 1'b0;
  int holdoff_left = 0;

  indexed_array_table_engine_unit DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_n),
    .in_valid_i         (item_valid),
    .in_stall_o         (item_stall),
    .opcode_i           (item_opcode),
    .position_i         (item_position),
    .value_i            (item_value),
    .out_valid_o        (reply_valid),
    .out_stall_i        (reply_stall),
    .status_o           (reply_status),
    .element_value_o    (reply_value),
    .element_position_o (reply_position),
    .last_o             (reply_last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void push_reply(logic [1:0] st, logic [VAL_W-1:0] v, int p, logic l);
    table_reply_t r;
    r.status = st;
    r.value = v;
    r.position = POS_W'(p);
    r.last = l;
    replies_due.push_back(r);
  endfunction

  // shadow of the element table; queues the replies one accepted item causes
  function automatic void apply_table_op(logic [2:0] op, logic [POS_W-1:0] pos,
                                         logic [VAL_W-1:0] val);
    int n;
    int hit;
    int p;
    n = shadow_count;
    hit = 0;
    p = int'(pos);
    case (op)
      OP_LIST: begin
        if (n == 0) begin
          push_reply(STAT_OK, '0, 0, 1'b1);
        end else begin
          for (int i = 0; i < n; i++)
            push_reply(STAT_OK, shadow_elems[i], i + 1, i == n - 1);
        end
      end
      OP_INSERT: begin
        if (n >= DEPTH) begin
          push_reply(STAT_FULL, val, 0, 1'b1);
        end else if (p < 1 || p > n + 1) begin
          push_reply(STAT_RANGE, val, 0, 1'b1);
        end else begin
          for (int i = n; i > p - 1; i--)
            shadow_elems[i] = shadow_elems[i-1];
          shadow_elems[p-1] = val;
          shadow_count = n + 1;
          push_reply(STAT_OK, val, p, 1'b1);
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > n) begin
          push_reply(STAT_RANGE, val, 0, 1'b1);
        end else begin
          push_reply(STAT_OK, shadow_elems[p-1], p, 1'b1);
          for (int i = p - 1; i + 1 < n; i++)
            shadow_elems[i] = shadow_elems[i+1];
          shadow_count = n - 1;
        end
      end
      OP_UPDATE: begin
        if (p < 1 || p > n) begin
          push_reply(STAT_RANGE, val, 0, 1'b1);
        end else begin
          shadow_elems[p-1] = val;
          push_reply(STAT_OK, val, p, 1'b1);
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < n; i++)
          if (hit == 0 && shadow_elems[i] == val) hit = i + 1;
        if (hit != 0) push_reply(STAT_OK, val, hit, 1'b1);
        else push_reply(STAT_NOTFOUND, val, 0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, table_reply_t want, table_reply_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected st=%0d val=%h pos=%0d last=%0b, got st=%0d val=%h pos=%0d last=%0b",
               what, want.status, want.value, want.position, want.last,
               got.status, got.value, got.position, got.last);
  endfunction

  always @(posedge clk_i) begin : accept_side
    int depth_before;
    table_reply_t got;
    table_reply_t want;
    if (item_valid && !item_stall) begin
      depth_before = replies_due.size();
      apply_table_op(item_opcode, item_position, item_value);
      if (item_typed) begin
        while (replies_due.size() > depth_before) void'(replies_due.pop_back());
        replies_due.push_back(item_reply);
      end
    end
    if (reply_valid && !reply_stall) begin
      got = '{reply_status, reply_value, reply_position, reply_last};
      if (replies_due.size() == 0) begin
        note_mismatch("unexpected item", '0, got);
      end else begin
        want = replies_due.pop_front();
        if (want !== got) note_mismatch("reply mismatch", want, got);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        reply_stall <= 1'b1;
        holdoff_left--;
      end else begin
        reply_stall <= rx_gaps_on && ($urandom_range(0, 99) < 11);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((item_valid && !item_stall) || (reply_valid && !reply_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_indexed_array_table_engine_unit NOT OK");
    $finish;
  end

  task automatic put_item(logic [2:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                          logic typed, table_reply_t reply);
    while (tx_gaps_on && $urandom_range(0, 99) < 11) begin
      item_valid <= 1'b0;
      @(posedge clk_i);
    end
    item_valid    <= 1'b1;
    item_opcode   <= op;
    item_position <= pos;
    item_value    <= val;
    item_typed    <= typed;
    item_reply    <= reply;
    @(posedge clk_i);
    while (item_stall) @(posedge clk_i);
  endtask

  // small values make duplicates so search has to pick the first hit
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3, 4: return VAL_W'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // grow_pct steers the table size: share of inserts among the editing ops
  task automatic send_random(int grow_pct);
    logic [2:0] op;
    logic [VAL_W-1:0] val;
    int pos;
    int n;
    int r;
    int r2;
    n = shadow_count;
    val = pick_value();
    pos = $urandom_range(1, n + 1);
    r = $urandom_range(0, 99);
    if (r < 6) begin
      op = 3'($urandom_range(0, 7));
      pos = $urandom_range(0, 127);
    end else if (r < 11) begin
      op = OP_LIST;
    end else if (r < 30) begin
      op = OP_SEARCH;
      if (n > 0 && $urandom_range(0, 1) == 1) val = shadow_elems[$urandom_range(0, n - 1)];
    end else begin
      r2 = $urandom_range(0, 99);
      if (r2 < grow_pct) begin
        op = OP_INSERT;
      end else begin
        op = (r2 % 2 == 1) ? OP_DELETE : OP_UPDATE;
        pos = (n > 0) ? $urandom_range(1, n) : 1;
      end
    end
    put_item(op, POS_W'(pos), val, 1'b0, '0);
  endtask

  initial begin
    int tries;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    for (int k = 0; k < SCRIPT_LEN; k++)
      put_item(SCRIPT[k].op, SCRIPT[k].pos, SCRIPT[k].val, SCRIPT[k].typed,
               '{SCRIPT[k].st, SCRIPT[k].eval, SCRIPT[k].epos, 1'b1});

    repeat (60) send_random(50);

    // back to back, no idling on either side
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (40) send_random(50);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;

    // fill the table, then hit it while full
    tries = 0;
    while (shadow_count < DEPTH && tries < 160) begin
      send_random(90);
      tries++;
    end
    repeat (4)
      put_item(OP_INSERT, POS_W'($urandom_range(0, 127)), pick_value(), 1'b0, '0);
    put_item(OP_LIST, '0, '0, 1'b0, '0);

    // long receiver hold-off during a full listing; sender keeps pushing
    hold_request = 1'b1;
    repeat (20) send_random(50);

    // sender drops valid and lets the accept side queue the last accepted item,
    // then waits until every reply is back
    item_valid <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);

    repeat (60) send_random(25);

    item_valid <= 1'b0;
    @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    mismatch_count += replies_due.size();
    if (mismatch_count == 0)
      $display("tb_indexed_array_table_engine_unit OK");
    else
      $display("tb_indexed_array_table_engine_unit NOT OK");
    $finish;
  end

endmodule

### sim.f
sv/iate_pkg.sv
sv/iate_cell.sv
sv/indexed_array_table_engine_unit.sv
test/tb_indexed_array_table_engine_unit.sv
